// ===== hw/rtl/qvd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvd_pkg
// Shared types, constants and helpers of the quote varint field decoder.
// ----------------------------------------------------------------------------
package qvd_pkg;

	localparam int DEF_MAX_FIELD_BYTES = 6;
	localparam int POS_W               = 3;
	localparam int VALUE_W             = 32;

	// Byte flag positions.
	localparam int CONT_BIT = 7;
	localparam int SIGN_BIT = 6;

	// A negated field is this base minus the sum.
	localparam logic [VALUE_W-1:0] NEG_BASE = 32'h0000_0040;

	typedef struct packed {
		logic signed [VALUE_W-1:0] field_value;
		logic                      too_long;
	} qvd_result_t;

	// Weight of the seven payload bits of byte number pos: 1 for the first
	// byte, 2^(7*pos-1) after it, cut to the value width.
	function automatic logic [VALUE_W-1:0] term_of(input logic [6:0] low7,
		input logic [POS_W-1:0] pos);
		logic [47:0] wide;
		logic [47:0] shifted;
		logic [5:0]  sh;
		wide    = {41'd0, low7};
		sh      = ({3'd0, pos} << 3) - {3'd0, pos} - 6'd1;
		shifted = wide << sh;
		if (pos == '0) begin
			term_of = wide[VALUE_W-1:0];
		end else begin
			term_of = shifted[VALUE_W-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/qvd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvd_step
// Field state registers and the per-byte decode logic.
// ----------------------------------------------------------------------------
module qvd_step #(
	parameter int MAX_FIELD_BYTES = qvd_pkg::DEF_MAX_FIELD_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step_en,
	input  logic [7:0]                       data_byte,
	input  logic                             signed_field,
	output logic                             res_valid,
	output qvd_pkg::qvd_result_t             res
);
	import qvd_pkg::*;

	logic [VALUE_W-1:0] acc_q;
	logic [POS_W-1:0]   pos_q;
	logic               neg_q;

	logic [VALUE_W-1:0] sum;
	logic               neg;
	logic               last_byte;
	logic               over_limit;

	always_comb begin
		sum        = acc_q + term_of(data_byte[6:0], pos_q);
		neg        = (pos_q == '0) ? (signed_field & data_byte[SIGN_BIT]) : neg_q;
		last_byte  = ~data_byte[CONT_BIT];
		over_limit = ({1'b0, pos_q} + 4'd1) >= 4'(MAX_FIELD_BYTES);
		res_valid  = last_byte | over_limit;
		if (last_byte) begin
			res.field_value = neg ? $signed(NEG_BASE - sum) : $signed(sum);
			res.too_long    = 1'b0;
		end else begin
			res.field_value = '0;
			res.too_long    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
			neg_q <= 1'b0;
		end else if (step_en) begin
			if (res_valid) begin
				acc_q <= '0;
				pos_q <= '0;
				neg_q <= 1'b0;
			end else begin
				acc_q <= sum;
				pos_q <= pos_q + 3'd1;
				neg_q <= neg;
			end
		end
	end

endmodule

// ===== hw/rtl/quote_varint_field_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quote_varint_field_decoder
// Streaming decoder of variable-length integer fields in a quote byte stream.
// ----------------------------------------------------------------------------
// The block takes one byte per word and returns one word per completed field.
// A byte with bit 7 set continues the field; the first byte carries seven
// value bits at weight 1, the second at weight 64, and every later byte at a
// further factor of 128, all summed modulo 2^32. When the signed flag is set
// on the first byte of a field and that byte has bit 6 set, the result is 64
// minus the sum. A field that is still open after MAX_FIELD_BYTES bytes gives
// a word with too_long set and value zero, and the next byte opens a new
// field. Throughput is one byte per cycle while the output side takes words:
// each byte passes an input register, one stage of decode logic (a shift and
// a 32-bit add) and an output register, where a result word is held until
// the output side is ready. The input register can take one new byte while
// a finished word waits on the output side.
// ----------------------------------------------------------------------------
module quote_varint_field_decoder #(
	parameter int MAX_FIELD_BYTES = qvd_pkg::DEF_MAX_FIELD_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,  // [0] signed_field
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] field_value
	output logic [0:0]  m_axis_tuser   // [0] too_long
);
	import qvd_pkg::*;

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       sgn_s1;

	// Output stage.
	logic        out_valid_q;
	qvd_result_t out_res_q;

	logic        out_free;
	logic        advance;
	logic        res_valid;
	qvd_result_t res;

	// The output register can take a new word when it is empty or being read.
	assign out_free      = ~out_valid_q | m_axis_tready;
	assign advance       = valid_s1 & out_free;
	assign s_axis_tready = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			sgn_s1  <= s_axis_tuser[0];
		end
	end

	qvd_step #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (advance),
		.data_byte    (byte_s1),
		.signed_field (sgn_s1),
		.res_valid    (res_valid),
		.res          (res)
	);

	// A byte that closes no field leaves the output register empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_res_q.field_value;
	assign m_axis_tuser[0] = out_res_q.too_long;

endmodule

// ===== hw/rtl/qvd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvd_checker
// Port-level checks of the quote varint field decoder, bound to the top level.
// ----------------------------------------------------------------------------
module qvd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready
);

	// An overlong field always reports a zero value.
	a_too_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
		else $error("too_long word with nonzero value");

	// The input side only stalls while a word is held back on the output side.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// A word that is not taken stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	// A word appearing on an idle output needs a source byte that passed the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid ##1 m_axis_tvalid |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("output word without a source byte");

endmodule

bind quote_varint_field_decoder qvd_checker u_qvd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

// ===== dv/quote_varint_field_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quote_varint_field_decoder_tb
// Self-checking bench for the streaming varint field decoder.
// ----------------------------------------------------------------------------
// A directed set of fields comes first: the extreme bytes, signed and unsigned
// one-byte fields, a signed first byte with bit 6 clear, a flag change on a
// later byte, a full-length field that wraps, and a field that runs too long.
// Random fields of random length and content follow, with some raw noise
// bytes among them. The sender idles in bursts. The receiver stalls on a
// pattern of its own and holds off once for a long stretch, so that the block
// fills up and stalls its input. A scoreboard class decodes every accepted
// byte and checks each output word against the oldest decoded field.
// ----------------------------------------------------------------------------
module quote_varint_field_decoder_tb;

	import qvd_pkg::*;

	localparam int FIELD_MAX   = DEF_MAX_FIELD_BYTES;
	localparam int BYTE_TARGET = 1500;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 20;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_HALF,
		RDY_RARE,
		RDY_TOGGLE
	} ready_mode_t;

	// Decodes the byte stream on its own and keeps the fields that the block
	// still owes, oldest first.
	class field_scoreboard;
		logic [VALUE_W-1:0] partial_sum;
		logic [POS_W-1:0]   next_pos;
		logic               negate;
		qvd_result_t        fields_due[$];
		int                 mismatches;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			partial_sum = '0;
			next_pos    = '0;
			negate      = 1'b0;
		endfunction

		function void decode_byte(input logic [7:0] b, input logic sgn);
			logic [47:0]        weighted;
			logic [VALUE_W-1:0] sum;
			qvd_result_t        fld;
			if (next_pos == '0) begin
				// The sign flag only matters on the first byte of a field.
				negate   = sgn && b[SIGN_BIT];
				weighted = {41'd0, b[6:0]};
			end else begin
				weighted = {41'd0, b[6:0]} << (7 * int'(next_pos) - 1);
			end
			sum = partial_sum + weighted[VALUE_W-1:0];
			if (!b[CONT_BIT]) begin
				fld.field_value = negate ? (NEG_BASE - sum) : sum;
				fld.too_long    = 1'b0;
				fields_due = {fields_due, fld};
				restart();
			end else if (int'(next_pos) + 1 >= FIELD_MAX) begin
				fld.field_value = '0;
				fld.too_long    = 1'b1;
				fields_due = {fields_due, fld};
				restart();
			end else begin
				partial_sum = sum;
				next_pos    = next_pos + 1'b1;
			end
		endfunction

		function void compare_field(input logic [VALUE_W-1:0] value, input logic overrun);
			qvd_result_t want;
			if (fields_due.size() == 0) begin
				$display("%t: word with no field pending: value %h too_long %b",
					$realtime, value, overrun);
				mismatches++;
				return;
			end
			want = fields_due.pop_front();
			if (value !== want.field_value) begin
				$display("%t: field_value expected %h actual %h",
					$realtime, want.field_value, value);
				mismatches++;
			end
			if (overrun !== want.too_long) begin
				$display("%t: too_long expected %b actual %b",
					$realtime, want.too_long, overrun);
				mismatches++;
			end
		endfunction

		function int pending();
			return fields_due.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;  // [7:0] data_byte
	logic [0:0]  s_axis_tuser = '0;  // [0] signed_field
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // [31:0] field_value
	logic [0:0]  m_axis_tuser;       // [0] too_long

	field_scoreboard fields = new();

	int          bytes_sent = 0;
	int          burst_left = 0;
	int          cycles = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int          mode_left = 0;
	ready_mode_t rdy_mode = RDY_ALWAYS;

	quote_varint_field_decoder #(
		.MAX_FIELD_BYTES(FIELD_MAX)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Offers one byte and returns at the edge where it is taken. Between
	// bursts the valid line drops for a random gap; some bursts are long so
	// that there are stretches with no idling at all.
	task automatic send_byte(input logic [7:0] b, input logic sgn);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(50, 200);
			end else begin
				burst_left = $urandom_range(1, 24);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= sgn;
		do @(posedge clk); while (!s_axis_tready);
		fields.decode_byte(b, sgn);
		bytes_sent++;
		burst_left--;
	endtask

	// Sends a well-formed field of nbytes bytes, or with overrun set a run of
	// nbytes continuation bytes that never closes the field.
	task automatic send_field(input int nbytes, input bit overrun);
		logic [7:0] b;
		int         k;
		for (k = 0; k < nbytes; k++) begin
			case ($urandom_range(0, 7))
				0: b[6:0] = 7'h00;
				1: b[6:0] = 7'h7F;
				default: b[6:0] = 7'($urandom);
			endcase
			b[7] = overrun || (k != nbytes - 1);
			send_byte(b, 1'($urandom_range(0, 1)));
		end
	endtask

	// Receiver: checks each word taken, then picks the next ready value. The
	// ready pattern switches between random modes, and once, on request, the
	// receiver holds off for a long stretch.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			fields.compare_field(m_axis_tdata, m_axis_tuser[0]);
		end
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rdy_mode  = ready_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 128);
			end else begin
				mode_left--;
			end
			case (rdy_mode)
				RDY_ALWAYS: m_axis_tready <= 1'b1;
				RDY_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
				RDY_RARE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
				RDY_TOGGLE: m_axis_tready <= ~m_axis_tready;
				default:    m_axis_tready <= 1'b1;
			endcase
		end
	end

	initial begin
		int roll;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-byte fields at the extremes, signed and unsigned.
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h40, 1'b1);  // signed, bit 6 set: 64 - 64
		send_byte(8'h7F, 1'b1);  // signed, bit 6 set: 64 - 127
		send_byte(8'h3F, 1'b1);  // signed flag but bit 6 clear: plain value
		send_byte(8'h40, 1'b0);
		// The flag on a later byte is ignored in both directions.
		send_byte(8'hC1, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h85, 1'b0);
		send_byte(8'h2A, 1'b1);
		// Longest field that still closes, all ones, negated and wrapping.
		send_byte(8'hFF, 1'b1);
		repeat (FIELD_MAX - 2) send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b0);
		// A field that never closes, then a fresh field right behind it.
		repeat (FIELD_MAX) send_byte(8'h80, 1'b1);
		send_byte(8'h01, 1'b0);

		// The long hold-off starts now, while random fields keep coming.
		hold_req <= 1'b1;

		while (bytes_sent < BYTE_TARGET) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else if (roll < 15) begin
				send_field(FIELD_MAX, 1'b1);
			end else if (roll < 45) begin
				send_field(1, 1'b0);
			end else begin
				send_field($urandom_range(2, FIELD_MAX), 1'b0);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (fields.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fields.mismatches == 0 && fields.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
